FILE: rtl/ole_pkg.sv
package ole_pkg;

  localparam int CAPACITY = 16;

  localparam int KIND_W = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 5;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_POS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INS_ORD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd4;

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_INDEX    = 2'd1,
    ST_OUT_OF_BOUND = 2'd2,
    ST_FULL         = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_INS_POS,
    OP_INS_ORD,
    OP_DELETE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic                   pos_zero;
    logic [POS_W-1:0]       position;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/ole_if.sv
interface ole_req_if;
  logic                             valid;
  logic                             ready;
  logic [ole_pkg::KIND_W-1:0]       kind;
  logic [ole_pkg::POS_W-1:0]        position;
  logic signed [ole_pkg::VAL_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface ole_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [ole_pkg::ST_W-1:0]         status;
  logic signed [ole_pkg::VAL_W-1:0] removed_value;
  logic [ole_pkg::LEN_W-1:0]        length;

  modport source (output valid, output status, output removed_value, output length,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input length,
                  output ready);
endinterface

FILE: rtl/ole_front.sv
module ole_front (
  ole_req_if.sink          req_i,
  input  ole_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output ole_pkg::cmd_t    cmd_o
);

  ole_pkg::op_e op;

  // decode the command kind; unknown kinds become a no-op
  always_comb begin
    unique case (req_i.kind)
      ole_pkg::KIND_CLEAR:   op = ole_pkg::OP_CLEAR;
      ole_pkg::KIND_APPEND:  op = ole_pkg::OP_APPEND;
      ole_pkg::KIND_INS_POS: op = ole_pkg::OP_INS_POS;
      ole_pkg::KIND_INS_ORD: op = ole_pkg::OP_INS_ORD;
      ole_pkg::KIND_DELETE:  op = ole_pkg::OP_DELETE;
      default:               op = ole_pkg::OP_NOP;
    endcase
  end

  assign req_i.ready    = !q_stat_i.full;
  assign push_o         = req_i.valid && !q_stat_i.full;
  assign cmd_o.op       = op;
  assign cmd_o.pos_zero = (req_i.position == '0);
  assign cmd_o.position = req_i.position;
  assign cmd_o.value    = req_i.value;

endmodule

FILE: rtl/ole_cmd_fifo.sv
module ole_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ole_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output ole_pkg::cmd_t    cmd_o,
  output ole_pkg::q_stat_t q_stat_o
);

  ole_pkg::cmd_t                slot_q [ole_pkg::QDEPTH];
  logic [ole_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ole_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ole_pkg::QCNT_W-1:0]   fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ole_pkg::QPTR_W'(ole_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == ole_pkg::QPTR_W'(ole_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = slot_q[rd_ptr_q];
  assign q_stat_o.full  = (fill_q == ole_pkg::QCNT_W'(ole_pkg::QDEPTH));
  assign q_stat_o.empty = (fill_q == '0);

endmodule

FILE: rtl/ole_back.sv
module ole_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ole_pkg::cmd_t    cmd_i,
  input  ole_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  ole_rsp_if.source        rsp_o
);

  localparam int N = ole_pkg::CAPACITY;

  logic signed [ole_pkg::VAL_W-1:0] ent_q [N];
  logic signed [ole_pkg::VAL_W-1:0] ent_d [N];
  logic signed [ole_pkg::VAL_W-1:0] prev_w [N];
  logic signed [ole_pkg::VAL_W-1:0] next_w [N];
  logic [ole_pkg::CNT_W-1:0]        count_q, count_d;

  logic                             rsp_valid_q;
  ole_pkg::status_e                 status_q, status_d;
  logic signed [ole_pkg::VAL_W-1:0] removed_q, removed_d;
  logic [ole_pkg::LEN_W-1:0]        length_q;

  logic                             do_ins, do_del, is_full;
  logic [ole_pkg::CNT_W-1:0]        slot, ord_slot;
  logic [ole_pkg::POS_W-1:0]        pos_m1;
  logic [ole_pkg::CMP_W-1:0]        pos_ext, cnt_ext;
  logic [N-1:0]                     ge;

  assign pop_o   = !q_stat_i.empty && (!rsp_valid_q || rsp_o.ready);
  assign is_full = (count_q == ole_pkg::CNT_W'(N));
  assign pos_m1  = cmd_i.position - 1'b1;
  assign pos_ext = ole_pkg::CMP_W'(cmd_i.position);
  assign cnt_ext = ole_pkg::CMP_W'(count_q);

  // first live entry not below the new value
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ge[i] = (ole_pkg::CNT_W'(i) < count_q) && (ent_q[i] >= cmd_i.value);
    end
    ord_slot = count_q;
    for (int i = N - 1; i >= 0; i--) begin
      if (ge[i]) ord_slot = ole_pkg::CNT_W'(i);
    end
  end

  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    slot      = count_q;
    status_d  = ole_pkg::ST_OK;
    removed_d = '0;
    count_d   = count_q;
    unique case (cmd_i.op)
      ole_pkg::OP_CLEAR: count_d = '0;
      ole_pkg::OP_APPEND: begin
        if (is_full) status_d = ole_pkg::ST_FULL;
        else         do_ins   = 1'b1;
      end
      ole_pkg::OP_INS_POS: begin
        slot = ole_pkg::CNT_W'(pos_m1);
        if (cmd_i.pos_zero)                       status_d = ole_pkg::ST_BAD_INDEX;
        else if (pos_ext > cnt_ext + 1'b1)        status_d = ole_pkg::ST_OUT_OF_BOUND;
        else if (is_full)                         status_d = ole_pkg::ST_FULL;
        else                                      do_ins   = 1'b1;
      end
      ole_pkg::OP_INS_ORD: begin
        slot = ord_slot;
        if (is_full) status_d = ole_pkg::ST_FULL;
        else         do_ins   = 1'b1;
      end
      ole_pkg::OP_DELETE: begin
        slot = ole_pkg::CNT_W'(pos_m1);
        if (cmd_i.pos_zero) begin
          status_d  = ole_pkg::ST_BAD_INDEX;
          removed_d = '1;
        end else if (pos_ext > cnt_ext) begin
          status_d  = ole_pkg::ST_OUT_OF_BOUND;
        end else begin
          do_del    = 1'b1;
          removed_d = ent_q[ole_pkg::IDX_W'(pos_m1)];
        end
      end
      default: ;
    endcase
    if (do_ins) count_d = count_q + 1'b1;
    if (do_del) count_d = count_q - 1'b1;
  end

  // neighbours of each cell for the shift
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_w[g] = cmd_i.value;
    end else begin : g_mid
      assign prev_w[g] = ent_q[g-1];
    end
    if (g == N - 1) begin : g_last
      assign next_w[g] = ent_q[g];
    end else begin : g_rest
      assign next_w[g] = ent_q[g+1];
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ent_d[i] = ent_q[i];
      if (do_ins) begin
        if (ole_pkg::CNT_W'(i) == slot)     ent_d[i] = cmd_i.value;
        else if (ole_pkg::CNT_W'(i) > slot) ent_d[i] = prev_w[i];
      end else if (do_del && (ole_pkg::CNT_W'(i) >= slot)) begin
        ent_d[i] = next_w[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < N; i++) begin
        ent_q[i] <= ent_d[i];
      end
      status_q  <= status_d;
      removed_q <= removed_d;
      length_q  <= ole_pkg::LEN_W'(count_d);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.length        = length_q;

endmodule

FILE: rtl/ordered_list_engine.sv
// Path: an accepted request is written into the command queue; the back end pops it once the
// response register is free, updates the list and registers the response.
// Throughput: one request per cycle while responses are taken; the shift cells apply any insert
// or delete at once, and the two-entry command queue absorbs a stalled response.
// Reset: rst_ni clears the list length, the command queue and the response valid flag;
// the entry cells are not reset and are never read before they are written.
module ordered_list_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  ole_req_if.sink   req_i,
  ole_rsp_if.source rsp_o
);

  // Front end: decode the request kind and push it into the queue.
  logic             push;
  logic             pop;
  ole_pkg::cmd_t    cmd_in;
  ole_pkg::cmd_t    cmd_out;
  ole_pkg::q_stat_t q_stat;

  ole_front u_front (
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  // Short queue: decouple request acceptance from list updates, so a
  // back-pressured response does not stall the request side at once.
  ole_cmd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .cmd_o    (cmd_out),
    .q_stat_o (q_stat)
  );

  // Back end: hold the list in a row of compare-and-shift cells, classify
  // the command against the current length and register the response.
  ole_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_out),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .rsp_o    (rsp_o)
  );

  // Never take a request while the queue is full.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !req_i.ready)
    else $error("request taken with a full queue");

  // Never drain an empty queue.
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  // A full status only comes back with the list at capacity.
  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ole_pkg::ST_FULL)) |-> (rsp_o.length == ole_pkg::FULL_LEN))
    else $error("full status with list below capacity");

  // A new response follows every pop.
  a_pop_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> rsp_o.valid)
    else $error("pop without response");

endmodule

FILE: dv/tb_ordered_list_engine.sv
module tb_ordered_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // Kinds with no meaning: the block must leave the list alone and answer with an OK status.
  localparam logic [ole_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [ole_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  localparam logic signed [ole_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ole_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [ole_pkg::VAL_W-1:0] VAL_NEG_ONE = -32'sd1;

  localparam int RANDOM_REQUESTS = 410;
  localparam int IDLE_PERCENT    = 17;
  localparam int DRAIN_CYCLES    = 4;
  localparam int CYCLE_LIMIT     = 100000;

  // One response: status, value taken out by a delete, list length afterwards.
  typedef struct {
    ole_pkg::status_e                 status;
    logic signed [ole_pkg::VAL_W-1:0] removed;
    logic [ole_pkg::LEN_W-1:0]        length;
  } list_rsp_t;

  // One line of the directed table. A row may be issued several times in a row
  // (reps); the value then steps down by one on each repeat. Where checked_by_hand
  // is set, the response is written into the row; otherwise the list model decides.
  typedef struct {
    logic [ole_pkg::KIND_W-1:0]       kind;
    logic [ole_pkg::POS_W-1:0]        position;
    logic signed [ole_pkg::VAL_W-1:0] value;
    int                               reps;
    bit                               checked_by_hand;
    list_rsp_t                        rsp;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni;

  ole_req_if req_if ();
  ole_rsp_if rsp_if ();

  ordered_list_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  int        list_entries[$];  // model of the list, front is position 1
  list_rsp_t rsp_due_q[$];     // responses owed by the block, oldest first
  cmd_row_t  cmd_rows[$];

  int err_count;
  int rsp_count;
  int cycle_count;
  bit steady;                  // set: neither side idles

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] MISMATCH response %0d: %s", $time, rsp_count, msg);
  endtask

  // Apply one request to the list model and return the response it owes.
  function automatic list_rsp_t apply_list_cmd(logic [ole_pkg::KIND_W-1:0] kind,
                                               logic [ole_pkg::POS_W-1:0] position,
                                               logic signed [ole_pkg::VAL_W-1:0] value);
    list_rsp_t r;
    int        slot;
    int        pos;
    r.status  = ole_pkg::ST_OK;
    r.removed = '0;
    pos       = int'(position);
    case (kind)
      ole_pkg::KIND_CLEAR: begin
        list_entries.delete();
      end
      ole_pkg::KIND_APPEND: begin
        if (list_entries.size() >= ole_pkg::CAPACITY) r.status = ole_pkg::ST_FULL;
        else list_entries.push_back(int'(value));
      end
      ole_pkg::KIND_INS_POS: begin
        // bad index wins over out of bound, which wins over full
        if (pos == 0) r.status = ole_pkg::ST_BAD_INDEX;
        else if (pos > list_entries.size() + 1) r.status = ole_pkg::ST_OUT_OF_BOUND;
        else if (list_entries.size() >= ole_pkg::CAPACITY) r.status = ole_pkg::ST_FULL;
        else list_entries.insert(pos - 1, int'(value));
      end
      ole_pkg::KIND_INS_ORD: begin
        if (list_entries.size() >= ole_pkg::CAPACITY) begin
          r.status = ole_pkg::ST_FULL;
        end else begin
          // go in front of the first entry that is not below the value
          slot = 0;
          while (slot < list_entries.size() && list_entries[slot] < int'(value)) slot++;
          list_entries.insert(slot, int'(value));
        end
      end
      ole_pkg::KIND_DELETE: begin
        if (pos == 0) begin
          r.status  = ole_pkg::ST_BAD_INDEX;
          r.removed = VAL_NEG_ONE;
        end else if (pos > list_entries.size()) begin
          r.status = ole_pkg::ST_OUT_OF_BOUND;
        end else begin
          r.removed = list_entries[pos - 1];
          list_entries.delete(pos - 1);
        end
      end
      default: ;
    endcase
    r.length = ole_pkg::LEN_W'(list_entries.size());
    return r;
  endfunction

  function automatic void add_row(logic [ole_pkg::KIND_W-1:0] kind,
                                  logic [ole_pkg::POS_W-1:0] position,
                                  logic signed [ole_pkg::VAL_W-1:0] value, int reps,
                                  bit checked_by_hand, ole_pkg::status_e status,
                                  logic signed [ole_pkg::VAL_W-1:0] removed,
                                  logic [ole_pkg::LEN_W-1:0] length);
    cmd_row_t row;
    row.kind            = kind;
    row.position        = position;
    row.value           = value;
    row.reps            = reps;
    row.checked_by_hand = checked_by_hand;
    row.rsp.status      = status;
    row.rsp.removed     = removed;
    row.rsp.length      = length;
    cmd_rows.push_back(row);
  endfunction

  // Offer one request from a falling edge and hold it until the block takes it.
  // Valid is only ever lowered when an idle cycle really follows, so it is never
  // dropped and raised again in the same step.
  task automatic send_request(logic [ole_pkg::KIND_W-1:0] kind,
                              logic [ole_pkg::POS_W-1:0] position,
                              logic signed [ole_pkg::VAL_W-1:0] value, bit checked_by_hand,
                              list_rsp_t hand_rsp);
    list_rsp_t model_rsp;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.position <= position;
    req_if.value    <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // Taken at this edge: advance the model in order of acceptance.
    model_rsp = apply_list_cmd(kind, position, value);
    rsp_due_q.push_back(checked_by_hand ? hand_rsp : model_rsp);
    @(negedge clk_i);
  endtask

  // Response side: stall at random, except during the steady stretch.
  always @(negedge clk_i) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Compare every accepted response with the oldest one owed.
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_due_q.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = rsp_due_q.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status got %0d, want %0d", rsp_if.status, want.status));
        if (rsp_if.removed_value !== want.removed)
          report_mismatch($sformatf("removed_value got %0d, want %0d",
                                    rsp_if.removed_value, want.removed));
        if (rsp_if.length !== want.length)
          report_mismatch($sformatf("length got %0d, want %0d", rsp_if.length, want.length));
      end
      rsp_count++;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d responses outstanding", $time, rsp_due_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    list_rsp_t                        no_rsp;
    logic [ole_pkg::KIND_W-1:0]       kind;
    logic [ole_pkg::POS_W-1:0]        position;
    logic signed [ole_pkg::VAL_W-1:0] value;
    int                               pick;
    int                               grow;
    bit                               filling;

    err_count       = 0;
    rsp_count       = 0;
    cycle_count     = 0;
    steady          = 1'b0;
    filling         = 1'b1;
    no_rsp.status   = ole_pkg::ST_OK;
    no_rsp.removed  = '0;
    no_rsp.length   = '0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = ole_pkg::KIND_CLEAR;
    req_if.position = '0;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;

    // Directed table. Hand-written responses where they are plain to see.
    // Empty list straight after reset: the bad-index and out-of-bound paths.
    add_row(ole_pkg::KIND_DELETE,  8'd1, '0,     1, 1, ole_pkg::ST_OUT_OF_BOUND, '0, 5'd0);
    add_row(ole_pkg::KIND_DELETE,  8'd0, '0,     1, 1, ole_pkg::ST_BAD_INDEX, VAL_NEG_ONE,
            5'd0);
    add_row(ole_pkg::KIND_INS_POS, 8'd0, 32'sd7, 1, 1, ole_pkg::ST_BAD_INDEX, '0, 5'd0);
    add_row(ole_pkg::KIND_INS_POS, 8'd2, 32'sd7, 1, 1, ole_pkg::ST_OUT_OF_BOUND, '0, 5'd0);
    // Ordered insert into an empty list, then the value extremes.
    add_row(ole_pkg::KIND_INS_ORD, 8'd0, 32'sd5, 1, 1, ole_pkg::ST_OK, '0, 5'd1);
    add_row(ole_pkg::KIND_APPEND,  8'd0, VAL_MIN, 1, 1, ole_pkg::ST_OK, '0, 5'd2);
    add_row(ole_pkg::KIND_INS_POS, 8'd1, VAL_MAX, 1, 1, ole_pkg::ST_OK, '0, 5'd3);
    // Position one past the end appends.
    add_row(ole_pkg::KIND_INS_POS, 8'd4, VAL_NEG_ONE, 1, 1, ole_pkg::ST_OK, '0, 5'd4);
    // Ordered insert of an equal value and of both extremes.
    add_row(ole_pkg::KIND_INS_ORD, 8'd0,   32'sd5,  1, 0, ole_pkg::ST_OK, '0, '0);
    add_row(ole_pkg::KIND_INS_ORD, 8'd0,   VAL_MAX, 1, 0, ole_pkg::ST_OK, '0, '0);
    add_row(ole_pkg::KIND_INS_ORD, 8'd255, VAL_MIN, 1, 0, ole_pkg::ST_OK, '0, '0);
    add_row(ole_pkg::KIND_DELETE,  8'd255, '0, 1, 1, ole_pkg::ST_OUT_OF_BOUND, '0, 5'd7);
    add_row(ole_pkg::KIND_DELETE,  8'd3,   '0, 1, 0, ole_pkg::ST_OK, '0, '0);
    add_row(ole_pkg::KIND_DELETE,  8'd6,   '0, 1, 0, ole_pkg::ST_OK, '0, '0);
    // Unused kinds do nothing.
    add_row(KIND_UNUSED_LO, 8'd0,   '0,          1, 1, ole_pkg::ST_OK, '0, 5'd5);
    add_row(KIND_UNUSED_HI, 8'd255, VAL_NEG_ONE, 1, 1, ole_pkg::ST_OK, '0, 5'd5);
    add_row(ole_pkg::KIND_CLEAR,   8'd0, '0, 1, 1, ole_pkg::ST_OK, '0, 5'd0);
    // Fill to capacity with falling values, then hit the full list every way.
    add_row(ole_pkg::KIND_INS_ORD, 8'd0, 32'sd100, ole_pkg::CAPACITY, 0, ole_pkg::ST_OK,
            '0, '0);
    add_row(ole_pkg::KIND_APPEND,  8'd0,  32'sd1, 1, 1, ole_pkg::ST_FULL, '0,
            ole_pkg::FULL_LEN);
    add_row(ole_pkg::KIND_INS_ORD, 8'd0,  32'sd1, 1, 1, ole_pkg::ST_FULL, '0,
            ole_pkg::FULL_LEN);
    add_row(ole_pkg::KIND_INS_POS, 8'd17, 32'sd1, 1, 1, ole_pkg::ST_FULL, '0,
            ole_pkg::FULL_LEN);
    add_row(ole_pkg::KIND_INS_POS, 8'd18, 32'sd1, 1, 1, ole_pkg::ST_OUT_OF_BOUND, '0,
            ole_pkg::FULL_LEN);
    add_row(ole_pkg::KIND_INS_POS, 8'd0,  32'sd1, 1, 1, ole_pkg::ST_BAD_INDEX, '0,
            ole_pkg::FULL_LEN);
    add_row(ole_pkg::KIND_DELETE,  8'd16, '0, 1, 0, ole_pkg::ST_OK, '0, '0);
    add_row(ole_pkg::KIND_DELETE,  8'd1,  '0, 1, 0, ole_pkg::ST_OK, '0, '0);
    add_row(ole_pkg::KIND_CLEAR,   8'd0,  '0, 1, 1, ole_pkg::ST_OK, '0, 5'd0);

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (cmd_rows[r]) begin
      for (int rep = 0; rep < cmd_rows[r].reps; rep++) begin
        send_request(cmd_rows[r].kind, cmd_rows[r].position, cmd_rows[r].value - rep,
                     cmd_rows[r].checked_by_hand, cmd_rows[r].rsp);
      end
    end

    // Random part: swing between filling and draining so the list spends time
    // both near empty and at capacity. A stretch in the middle runs with no idling.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 150 && n < 250);
      if (n % 60 == 0) filling = ~filling;
      grow = filling ? 70 : 35;

      pick = $urandom_range(99);
      if (pick < 2) kind = ole_pkg::KIND_CLEAR;
      else if (pick < 5)
        kind = ole_pkg::KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      else if ($urandom_range(99) < grow) begin
        case ($urandom_range(2))
          0:       kind = ole_pkg::KIND_APPEND;
          1:       kind = ole_pkg::KIND_INS_POS;
          default: kind = ole_pkg::KIND_INS_ORD;
        endcase
      end else kind = ole_pkg::KIND_DELETE;

      // Mostly valid positions, with zero, just past the end and wild ones mixed in.
      pick = $urandom_range(99);
      if (pick < 8) position = '0;
      else if (pick < 18) position = ole_pkg::POS_W'($urandom_range(255));
      else if (pick < 24)
        position = ole_pkg::POS_W'(list_entries.size() + $urandom_range(2, 1));
      else position = ole_pkg::POS_W'($urandom_range(list_entries.size() + 1, 1));

      // A narrow band gives plenty of equal values for the ordered insert.
      pick = $urandom_range(99);
      if (pick < 30) value = ole_pkg::VAL_W'($signed($urandom_range(16)) - 8);
      else if (pick < 40) begin
        case ($urandom_range(3))
          0:       value = VAL_MIN;
          1:       value = VAL_MAX;
          2:       value = VAL_NEG_ONE;
          default: value = '0;
        endcase
      end else value = $urandom;

      send_request(kind, position, value, 1'b0, no_rsp);
    end
    steady = 1'b0;
    req_if.valid <= 1'b0;

    // Drain: wait for every owed response, then watch for strays.
    while (rsp_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ole_pkg.sv
rtl/ole_if.sv
rtl/ole_front.sv
rtl/ole_cmd_fifo.sv
rtl/ole_back.sv
rtl/ordered_list_engine.sv
dv/tb_ordered_list_engine.sv
